// ===== rtl/ffpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;
	localparam int OFF_W  = 12;
	localparam int SIZE_W = 13;
	localparam int STAT_W = 2;
	localparam int SIZE_ALIGN = 8;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD_SIZE  = 2'd1;
	localparam status_t ST_NO_SPACE  = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	typedef logic cmd_t;
	localparam cmd_t CMD_ALLOC = 1'b0;
	localparam cmd_t CMD_FREE  = 1'b1;

	typedef struct packed {
		logic              used;
		logic [OFF_W-1:0]  start_off;
		logic [SIZE_W-1:0] end_off;
	} slot_t;
endpackage
`default_nettype wire

// ===== rtl/ffpa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ffpa_in_if import ffpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [SIZE_W-1:0] request_bytes;
	logic [OFF_W-1:0]  free_offset;
	modport source (output valid, command, request_bytes, free_offset, input ready);
	modport sink (input valid, command, request_bytes, free_offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffpa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ffpa_out_if import ffpa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFF_W-1:0] region_offset;
	status_t          status;
	modport source (output valid, region_offset, status, input ready);
	modport sink (input valid, region_offset, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffpa_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one granule: hold its busy flag, take the neighbour's flag on shift
module ffpa_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic shift,
	input  wire logic d,
	output logic      q
);
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (shift) begin
			busy_q <= d;
		end
	end

	assign q = busy_q;
endmodule
`default_nettype wire

// ===== rtl/ffpa_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ring of granule cells; the head is granule k after k shifts
module ffpa_ring #(
	parameter int NGRAN = 512
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic shift,
	input  wire logic upd,
	input  wire logic set_val,
	output logic      head
);
	logic [NGRAN-1:0] q;
	logic             tail_d;

	// rewrite the head flag as it wraps round to the tail
	assign tail_d = upd ? set_val : q[0];
	assign head   = q[0];

	for (genvar i = 0; i < NGRAN; i++) begin : g_cell
		logic d;
		if (i == NGRAN - 1) begin : g_tail
			assign d = tail_d;
		end else begin : g_mid
			assign d = q[i+1];
		end
		ffpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (q[i])
		);
	end
endmodule
`default_nettype wire

// ===== rtl/first_fit_page_allocator_unit.sv =====
// First-fit page allocator. One page of PAGE_BYTES is split into granules of GRANULE_BYTES,
// whose busy flags sit in a ring of cells that rotates one granule per cycle while it scans
// or marks. An allocate word (command 0) with a size that is zero or not a multiple of 8
// answers bad size without turning the ring; otherwise one full turn of the ring finds the
// lowest free run, the slot table is searched for the lowest empty slot (one read a cycle),
// the slot is written, and a second turn marks the granules busy. A free word (command 1)
// searches the table for the lowest used slot starting at free_offset and, on a hit, turns
// the ring once to release its granules. One word is worked on at a time; a finished result
// waits in an output register while the next word is taken. After reset the block sweeps
// the slot table, clearing every slot, and accepts nothing until then.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_page_allocator_unit import ffpa_pkg::*; #(
	parameter int PAGE_BYTES    = 4096,
	parameter int GRANULE_BYTES = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ffpa_in_if.sink    in_ch,
	ffpa_out_if.source out_ch
);
	localparam int NGRAN = PAGE_BYTES / GRANULE_BYTES;
	localparam int AW    = (NGRAN > 1) ? $clog2(NGRAN) : 1;
	localparam int CNTW  = $clog2(NGRAN + 1);
	// byte arithmetic width: covers page end plus the largest request
	localparam int CW    = ($clog2(PAGE_BYTES) + 2 > SIZE_W + 2) ?
	                       $clog2(PAGE_BYTES) + 2 : SIZE_W + 2;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_GSCAN, S_TSCAN, S_TWRITE, S_MARK, S_RESP
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic [OFF_W-1:0]  off_q;
	logic [CNTW-1:0]   cnt_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     run_q;
	logic [CW-1:0]     run_start_q;
	logic              found_q;
	logic [CW-1:0]     start_q;
	logic [CW-1:0]     stop_q;
	logic [AW-1:0]     hit_q;
	status_t           res_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	slot_t             rd_data_s1;
	logic              out_valid_q;
	logic [OFF_W-1:0]  out_off_q;
	status_t           out_st_q;

	slot_t             mem [NGRAN];
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	slot_t             mem_wd;

	logic              head;
	logic              ring_shift;
	logic              in_range;
	logic [CW-1:0]     run_n;
	logic [CW-1:0]     size_c;
	logic              bad_size;
	logic              slot_hit;

	assign size_c   = CW'(size_q);
	assign bad_size = (in_ch.request_bytes == '0) ||
	                  (in_ch.request_bytes[$clog2(SIZE_ALIGN)-1:0] != '0);

	// granule at head overlaps [start, stop)
	assign in_range = ((pos_q + CW'(GRANULE_BYTES)) > start_q) && (pos_q < stop_q);
	assign run_n    = head ? '0 : run_q + CW'(GRANULE_BYTES);

	assign ring_shift = (state_q == S_GSCAN) || (state_q == S_MARK);

	ffpa_ring #(.NGRAN(NGRAN)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (ring_shift),
		.upd     ((state_q == S_MARK) && in_range),
		.set_val (cmd_q == CMD_ALLOC),
		.head    (head)
	);

	assign slot_hit = (cmd_q == CMD_ALLOC) ? !rd_data_s1.used :
	                  (rd_data_s1.used && (rd_data_s1.start_off == off_q));

	// slot table: one write port, one registered read port
	always_comb begin
		mem_we = (state_q == S_CLEAR) || (state_q == S_TWRITE);
		mem_wa = (state_q == S_CLEAR) ? cnt_q[AW-1:0] : hit_q;
		mem_wd = '0;
		if (state_q == S_TWRITE) begin
			mem_wd.used      = (cmd_q == CMD_ALLOC);
			mem_wd.start_off = start_q[OFF_W-1:0];
			mem_wd.end_off   = stop_q[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded this cycle
			if (out_valid_q && out_ch.ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(NGRAN - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q       <= in_ch.command;
						size_q      <= in_ch.request_bytes;
						off_q       <= in_ch.free_offset;
						cnt_q       <= '0;
						pos_q       <= '0;
						run_q       <= '0;
						found_q     <= 1'b0;
						rd_vld_s1   <= 1'b0;
						priority if (in_ch.command == CMD_FREE) begin
							state_q <= S_TSCAN;
						end else if (bad_size) begin
							res_q   <= ST_BAD_SIZE;
							state_q <= S_RESP;
						end else begin
							state_q <= S_GSCAN;
						end
					end
				end
				S_GSCAN: begin
					// one granule a cycle; keep turning to bring the ring home
					run_q <= run_n;
					if (!head && (run_q == '0)) begin
						run_start_q <= pos_q;
					end
					if (!found_q && !head && (run_n >= size_c)) begin
						found_q <= 1'b1;
						start_q <= (run_q == '0) ? pos_q : run_start_q;
						stop_q  <= ((run_q == '0) ? pos_q : run_start_q) + size_c;
					end
					pos_q <= pos_q + CW'(GRANULE_BYTES);
					if (cnt_q == CNTW'(NGRAN - 1)) begin
						cnt_q     <= '0;
						rd_vld_s1 <= 1'b0;
						if (found_q || (!head && (run_n >= size_c))) begin
							state_q <= S_TSCAN;
						end else begin
							res_q   <= ST_NO_SPACE;
							state_q <= S_RESP;
						end
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				S_TSCAN: begin
					// issue one read a cycle, check the one issued before
					rd_vld_s1 <= (cnt_q < CNTW'(NGRAN));
					rd_idx_s1 <= cnt_q[AW-1:0];
					if (cnt_q < CNTW'(NGRAN)) begin
						cnt_q <= cnt_q + CNTW'(1);
					end
					if (rd_vld_s1) begin
						if (slot_hit) begin
							hit_q   <= rd_idx_s1;
							state_q <= S_TWRITE;
							if (cmd_q == CMD_FREE) begin
								start_q <= CW'(rd_data_s1.start_off);
								stop_q  <= CW'(rd_data_s1.end_off);
							end
						end else if (rd_idx_s1 == AW'(NGRAN - 1)) begin
							res_q   <= (cmd_q == CMD_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
							state_q <= S_RESP;
						end
					end
				end
				S_TWRITE: begin
					cnt_q   <= '0;
					pos_q   <= '0;
					state_q <= S_MARK;
				end
				S_MARK: begin
					pos_q <= pos_q + CW'(GRANULE_BYTES);
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(NGRAN - 1)) begin
						res_q   <= ST_OK;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					// hold until the output register is free
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_st_q    <= res_q;
						if (res_q != ST_OK) begin
							out_off_q <= '0;
						end else if (cmd_q == CMD_ALLOC) begin
							out_off_q <= start_q[OFF_W-1:0];
						end else begin
							out_off_q <= off_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.region_offset = out_off_q;
	assign out_ch.status        = out_st_q;

`ifndef SYNTHESIS
	a_rise_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q == S_RESP))
		else $error("result appeared outside the response step");
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.region_offset == '0))
		else $error("failed result carries a non-zero offset");
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q != S_IDLE))
		else $error("accepted word did not start work");
`endif
endmodule
`default_nettype wire
